>>> hw/rtl/ccrc_pkg.sv
// Shared types, register indexes and width-mode codes for the CRC engine.
// Bit-reversal helpers used by the byte-step logic.
// No dependencies.
package ccrc_pkg;

	localparam int unsigned CfgDataW = 32;
	localparam int unsigned CfgIdxW  = 3;

	localparam logic [CfgIdxW-1:0] REG_POLY        = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_INIT_VALUE  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_XOR_MASK    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_WIDTH_MODE  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_REFLECT_IN  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_REFLECT_OUT = 3'd5;

	localparam logic [1:0] MODE_XSUM  = 2'd0;
	localparam logic [1:0] MODE_CRC16 = 2'd1;
	localparam logic [1:0] MODE_CRC32 = 2'd2;

	localparam logic [31:0] POLY_RST       = 32'h0000_1021;
	localparam logic [31:0] INIT_VALUE_RST = 32'h0000_FFFF;
	localparam logic [31:0] XOR_MASK_RST   = 32'h0000_0000;
	localparam logic [1:0]  WIDTH_MODE_RST = MODE_CRC16;

	typedef struct packed {
		logic [31:0] poly;
		logic [31:0] init_value;
		logic [31:0] xor_mask;
		logic [1:0]  width_mode;
		logic        reflect_input;
		logic        reflect_output;
	} ccrc_cfg_t;

	function automatic logic [7:0] rev8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	function automatic logic [15:0] rev16(input logic [15:0] v);
		logic [15:0] r;
		for (int i = 0; i < 16; i++) begin
			r[i] = v[15-i];
		end
		return r;
	endfunction

	function automatic logic [31:0] rev32(input logic [31:0] v);
		logic [31:0] r;
		for (int i = 0; i < 32; i++) begin
			r[i] = v[31-i];
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/configurable_crc_engine_core.sv
// Top level of the configurable CRC engine: input register, running CRC register,
// result register and handshakes. Depends on ccrc_pkg, ccrc_cfg_regs, ccrc_byte_step.

// Takes one message byte per clock, while not stalled, on the in_valid/in_ready
// channel and emits one crc_value per message, on the byte marked last_byte, on
// the out_valid/out_ready channel. Throughput is one byte per cycle; a result
// is offered once its last byte has moved from the input register into the
// result register, and the eight-step shift/XOR update between them sets the
// clock limit. A full result register that is not taken stalls input only once
// a further last byte reaches it. Configuration is written by the user through
// cfg_we/cfg_index/cfg_data only while no message is in flight, which the block
// does not enforce; writing init_value reloads the running register at once.
module configurable_crc_engine_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ccrc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ccrc_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [7:0]                     data_byte,
	input  logic                           last_byte,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [31:0]                    crc_value
);

	ccrc_pkg::ccrc_cfg_t cfg;
	logic                init_load;

	logic        valid_s1;
	logic [7:0]  data_s1;
	logic        last_s1;
	logic [31:0] running_crc_q;
	logic        out_valid_q;
	logic [31:0] crc_value_q;

	logic [31:0] crc_next;
	logic [31:0] result;
	logic        out_free;
	logic        adv;

	ccrc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.init_load (init_load)
	);

	ccrc_byte_step u_step (
		.cfg       (cfg),
		.crc_cur   (running_crc_q),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.crc_next  (crc_next),
		.result    (result)
	);

	assign out_free = !out_valid_q || out_ready;
	// a non-last item never needs the result register
	assign adv      = valid_s1 && (!last_s1 || out_free);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_crc_q <= ccrc_pkg::INIT_VALUE_RST;
		end else if (init_load) begin
			running_crc_q <= cfg_data;
		end else if (adv) begin
			running_crc_q <= crc_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && last_s1) begin
			crc_value_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign crc_value = crc_value_q;

	// a stalled input item keeps its byte
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(data_s1) && $stable(last_s1))
		else $error("stalled input item changed");

	// end of message reloads the start value
	a_reload: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 && !cfg_we |=> running_crc_q == $past(cfg.init_value))
		else $error("running CRC not reloaded after last item");

	// CRC-16 keeps the upper half clear after each byte
	a_crc16_upper: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !last_s1 && !cfg_we && cfg.width_mode == ccrc_pkg::MODE_CRC16
		|=> running_crc_q[31:16] == 16'h0000)
		else $error("CRC-16 upper bits not zero");

	// a result only comes from a last item
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(valid_s1 && last_s1))
		else $error("result without last item");

	// a new result never overwrites an untaken one
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_ready |-> !(adv && last_s1))
		else $error("result register overwritten");

endmodule

>>> hw/rtl/ccrc_cfg_regs.sv
// Configuration register file of the CRC engine: write decode and storage.
// Depends on ccrc_pkg.
module ccrc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ccrc_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ccrc_pkg::CfgDataW-1:0]  cfg_data,
	output ccrc_pkg::ccrc_cfg_t            cfg,
	output logic                           init_load
);

	ccrc_pkg::ccrc_cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poly           <= ccrc_pkg::POLY_RST;
			cfg_q.init_value     <= ccrc_pkg::INIT_VALUE_RST;
			cfg_q.xor_mask       <= ccrc_pkg::XOR_MASK_RST;
			cfg_q.width_mode     <= ccrc_pkg::WIDTH_MODE_RST;
			cfg_q.reflect_input  <= 1'b0;
			cfg_q.reflect_output <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ccrc_pkg::REG_POLY:        cfg_q.poly           <= cfg_data;
				ccrc_pkg::REG_INIT_VALUE:  cfg_q.init_value     <= cfg_data;
				ccrc_pkg::REG_XOR_MASK:    cfg_q.xor_mask       <= cfg_data;
				ccrc_pkg::REG_WIDTH_MODE:  cfg_q.width_mode     <= cfg_data[1:0];
				ccrc_pkg::REG_REFLECT_IN:  cfg_q.reflect_input  <= cfg_data[0];
				ccrc_pkg::REG_REFLECT_OUT: cfg_q.reflect_output <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg       = cfg_q;
	// init write also restarts the running register
	assign init_load = cfg_we && (cfg_index == ccrc_pkg::REG_INIT_VALUE);

endmodule

>>> hw/rtl/ccrc_byte_step.sv
// Combinational byte update: eight shift/XOR steps per CRC width, checksum fold,
// output reflection and final mask. Depends on ccrc_pkg.
module ccrc_byte_step (
	input  ccrc_pkg::ccrc_cfg_t cfg,
	input  logic [31:0]         crc_cur,
	input  logic [7:0]          data_byte,
	input  logic                last_byte,
	output logic [31:0]         crc_next,
	output logic [31:0]         result
);

	logic [7:0]  b;
	logic [15:0] r16;
	logic [31:0] r32;
	logic [31:0] upd;
	logic [31:0] fin;

	always_comb begin
		b = cfg.reflect_input ? ccrc_pkg::rev8(data_byte) : data_byte;

		// upper poly bits never reach the low half, so CRC-16 runs 16 bits wide
		r16 = crc_cur[15:0] ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			r16 = r16[15] ? ((r16 << 1) ^ cfg.poly[15:0]) : (r16 << 1);
		end

		r32 = crc_cur ^ {b, 24'h000000};
		for (int i = 0; i < 8; i++) begin
			r32 = r32[31] ? ((r32 << 1) ^ cfg.poly) : (r32 << 1);
		end

		case (cfg.width_mode)
			ccrc_pkg::MODE_CRC16: upd = {16'h0000, r16};
			ccrc_pkg::MODE_CRC32: upd = r32;
			ccrc_pkg::MODE_XSUM:  upd = crc_cur ^ {24'h000000, b};
			default:              upd = crc_cur;
		endcase

		fin = upd;
		if (cfg.reflect_output) begin
			case (cfg.width_mode)
				ccrc_pkg::MODE_CRC16: fin = {16'h0000, ccrc_pkg::rev16(upd[15:0])};
				ccrc_pkg::MODE_CRC32: fin = ccrc_pkg::rev32(upd);
				default:              fin = upd;
			endcase
		end

		result   = fin ^ cfg.xor_mask;
		crc_next = last_byte ? cfg.init_value : upd;
	end

endmodule
